@@ hw/rtl/vmu_pkg.sv @@
package vmu_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_SUB   = 4'd1;
    localparam logic [3:0] FN_SCALE = 4'd2;
    localparam logic [3:0] FN_DIV   = 4'd3;
    localparam logic [3:0] FN_DOT   = 4'd4;
    localparam logic [3:0] FN_CROSS = 4'd5;
    localparam logic [3:0] FN_MAG   = 4'd6;
    localparam logic [3:0] FN_NORM  = 4'd7;
    localparam logic [3:0] FN_EQ    = 4'd8;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_SCALE,
        OP_DIV,
        OP_DOT,
        OP_CROSS,
        OP_MAG,
        OP_NORM,
        OP_EQ,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      s;
        logic             a_zero;
        logic             s_zero;
        logic             eq;
    } t_req;

endpackage

@@ hw/rtl/vmu_front.sv @@
module vmu_front (
    input  logic                  i_push,
    input  logic [3:0]            i_func,
    input  logic signed [31:0]    i_first_x,
    input  logic signed [31:0]    i_first_y,
    input  logic signed [31:0]    i_first_z,
    input  logic signed [31:0]    i_second_x,
    input  logic signed [31:0]    i_second_y,
    input  logic signed [31:0]    i_second_z,
    input  logic signed [31:0]    i_scalar,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_wr,
    output vmu_pkg::t_req         o_req
);
    import vmu_pkg::*;

    t_op op;

    always_comb begin
        case (i_func)
            FN_ADD:   op = OP_ADD;
            FN_SUB:   op = OP_SUB;
            FN_SCALE: op = OP_SCALE;
            FN_DIV:   op = OP_DIV;
            FN_DOT:   op = OP_DOT;
            FN_CROSS: op = OP_CROSS;
            FN_MAG:   op = OP_MAG;
            FN_NORM:  op = OP_NORM;
            FN_EQ:    op = OP_EQ;
            default:  op = OP_BAD;
        endcase
    end

    always_comb begin
        o_req.op     = op;
        o_req.a      = {i_first_z, i_first_y, i_first_x};
        o_req.b      = {i_second_z, i_second_y, i_second_x};
        o_req.s      = i_scalar;
        o_req.a_zero = (i_first_x == 32'sd0) && (i_first_y == 32'sd0) && (i_first_z == 32'sd0);
        o_req.s_zero = (i_scalar == 32'sd0);
        o_req.eq     = (i_first_x == i_second_x) && (i_first_y == i_second_y)
                    && (i_first_z == i_second_z);
    end

    assign o_full = i_q_full;
    assign o_wr   = i_push && !i_q_full;

endmodule

@@ hw/rtl/vmu_queue.sv @@
module vmu_queue #(
    parameter int DEPTH = vmu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  vmu_pkg::t_req i_data,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_vld,
    output vmu_pkg::t_req o_data
);
    import vmu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_req            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_wr;
    logic            do_rd;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rp];
    assign do_wr  = i_wr && !o_full;
    assign do_rd  = i_rd && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ hw/rtl/vmu_back.sv @@
module vmu_back #(
    parameter int FRAC_BITS = vmu_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_vld,
    input  vmu_pkg::t_req      i_req,
    output logic               o_req_rdy,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_scalar,
    output logic               o_is_equal,
    output logic               o_error
);
    import vmu_pkg::*;

    localparam int NW   = 32 + FRAC_BITS;
    localparam int SQ_N = 32;
    localparam int DV_N = NW;

    localparam logic signed [31:0] W_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] W_MIN = 32'sh80000000;

    typedef struct packed {
        t_op              op;
        logic [2:0][31:0] v;
        logic [31:0]      sc;
        logic             eq;
        logic             err;
        logic [31:0]      s_mag;
        logic [2:0]       q_neg;
    } t_carry;

    function automatic logic [31:0] sat66(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            sat66 = W_MAX;
        end else if (x < -66'sd2147483648) begin
            sat66 = W_MIN;
        end else begin
            sat66 = x[31:0];
        end
    endfunction

    logic en;

    // multiply stage
    logic               r_m_vld;
    t_op                r_m_op;
    logic signed [63:0] r_m_p [6];
    logic [2:0][31:0]   r_m_sum;
    logic [2:0][31:0]   r_m_a;
    logic [31:0]        r_m_s;
    logic               r_m_eq;
    logic               r_m_err;

    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
    logic signed [31:0] ml [6];
    logic signed [31:0] mr [6];
    logic signed [63:0] n_m_p [6];
    logic [2:0][31:0]   n_m_sum;
    logic signed [32:0] t33;

    assign en        = o_empty || i_pop;
    assign o_req_rdy = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(i_req.a[i]);
            b[i] = $signed(i_req.b[i]);
        end
        s = $signed(i_req.s);
        for (int i = 0; i < 6; i++) begin
            ml[i] = '0;
            mr[i] = '0;
        end
        case (i_req.op)
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    ml[i] = a[i];
                    mr[i] = s;
                end
            end
            OP_MAG, OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    ml[i] = a[i];
                    mr[i] = a[i];
                end
            end
            OP_CROSS: begin
                ml[0] = a[1]; mr[0] = b[2];
                ml[1] = a[2]; mr[1] = b[0];
                ml[2] = a[0]; mr[2] = b[1];
                ml[3] = a[2]; mr[3] = b[1];
                ml[4] = a[0]; mr[4] = b[2];
                ml[5] = a[1]; mr[5] = b[0];
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    ml[i] = a[i];
                    mr[i] = b[i];
                end
            end
        endcase
        for (int i = 0; i < 6; i++) begin
            n_m_p[i] = ml[i] * mr[i];
        end
        for (int i = 0; i < 3; i++) begin
            t33 = (i_req.op == OP_SUB) ? 33'(a[i]) - 33'(b[i]) : 33'(a[i]) + 33'(b[i]);
            n_m_sum[i] = sat66(66'(t33));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= i_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_op  <= i_req.op;
            r_m_p   <= n_m_p;
            r_m_sum <= n_m_sum;
            r_m_a   <= i_req.a;
            r_m_s   <= i_req.s;
            r_m_eq  <= i_req.eq;
            r_m_err <= (i_req.op == OP_BAD) || (i_req.op == OP_DIV && i_req.s_zero)
                    || (i_req.op == OP_NORM && i_req.a_zero);
        end
    end

    // combine stage
    logic              r_c_vld;
    t_carry            r_c;
    logic [63:0]       r_c_sq;
    logic [NW-1:0]     r_c_num [3];

    t_carry             n_c;
    logic [NW-1:0]      n_c_num [3];
    logic signed [65:0] t66;
    logic [32:0]        mag33;

    always_comb begin
        n_c.op    = r_m_op;
        n_c.v     = '0;
        n_c.sc    = '0;
        n_c.eq    = (r_m_op == OP_EQ) && r_m_eq;
        n_c.err   = r_m_err;
        mag33     = r_m_s[31] ? 33'd0 - {1'b0, r_m_s} : {1'b0, r_m_s};
        n_c.s_mag = mag33[31:0];
        t66       = '0;
        for (int i = 0; i < 3; i++) begin
            n_c.q_neg[i] = r_m_a[i][31] ^ ((r_m_op == OP_DIV) && r_m_s[31]);
            mag33        = r_m_a[i][31] ? 33'd0 - {1'b0, r_m_a[i]} : {1'b0, r_m_a[i]};
            n_c_num[i]   = {mag33[31:0], {FRAC_BITS{1'b0}}};
        end
        case (r_m_op)
            OP_ADD, OP_SUB: begin
                n_c.v = r_m_sum;
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    t66      = 66'(r_m_p[i]) >>> FRAC_BITS;
                    n_c.v[i] = sat66(t66);
                end
            end
            OP_DOT: begin
                t66    = (66'(r_m_p[0]) + 66'(r_m_p[1]) + 66'(r_m_p[2])) >>> FRAC_BITS;
                n_c.sc = sat66(t66);
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    t66      = (66'(r_m_p[i]) - 66'(r_m_p[i+3])) >>> FRAC_BITS;
                    n_c.v[i] = sat66(t66);
                end
            end
            default: begin
                n_c.v = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c     <= n_c;
            r_c_sq  <= 64'(r_m_p[0]) + 64'(r_m_p[1]) + 64'(r_m_p[2]);
            r_c_num <= n_c_num;
        end
    end

    // square root, one result bit per stage
    logic [SQ_N-1:0] r_q_vld;
    t_carry          r_q_c   [SQ_N];
    logic [63:0]     r_q_n   [SQ_N];
    logic [63:0]     r_q_r   [SQ_N];
    logic [NW-1:0]   r_q_num [SQ_N][3];

    logic [63:0] q_src_n [SQ_N];
    logic [63:0] q_src_r [SQ_N];
    logic [63:0] n_q_n   [SQ_N];
    logic [63:0] n_q_r   [SQ_N];
    logic [63:0] q_bit;

    always_comb begin
        q_src_n[0] = r_c_sq;
        q_src_r[0] = '0;
        for (int j = 1; j < SQ_N; j++) begin
            q_src_n[j] = r_q_n[j-1];
            q_src_r[j] = r_q_r[j-1];
        end
        q_bit = '0;
        for (int j = 0; j < SQ_N; j++) begin
            q_bit = 64'd1 << (62 - 2 * j);
            if (q_src_n[j] >= q_src_r[j] + q_bit) begin
                n_q_n[j] = q_src_n[j] - (q_src_r[j] + q_bit);
                n_q_r[j] = (q_src_r[j] >> 1) + q_bit;
            end else begin
                n_q_n[j] = q_src_n[j];
                n_q_r[j] = q_src_r[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= '0;
        end else if (en) begin
            r_q_vld <= {r_q_vld[SQ_N-2:0], r_c_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_c[0]   <= r_c;
            r_q_num[0] <= r_c_num;
            for (int j = 1; j < SQ_N; j++) begin
                r_q_c[j]   <= r_q_c[j-1];
                r_q_num[j] <= r_q_num[j-1];
            end
            r_q_n <= n_q_n;
            r_q_r <= n_q_r;
        end
    end

    // restoring divider, one quotient bit per stage, three lanes
    logic [DV_N-1:0] r_d_vld;
    t_carry          r_d_c   [DV_N];
    logic [31:0]     r_d_d   [DV_N];
    logic [31:0]     r_d_rem [DV_N][3];
    logic [NW-1:0]   r_d_num [DV_N][3];

    t_carry        d_src_c   [DV_N];
    logic [31:0]   d_src_d   [DV_N];
    logic [31:0]   d_src_rem [DV_N][3];
    logic [NW-1:0] d_src_num [DV_N][3];
    logic [31:0]   n_d_rem   [DV_N][3];
    logic [NW-1:0] n_d_num   [DV_N][3];
    logic [32:0]   rem_sh;
    logic [63:0]   root;

    always_comb begin
        root       = r_q_r[SQ_N-1];
        d_src_c[0] = r_q_c[SQ_N-1];
        if (r_q_c[SQ_N-1].op == OP_NORM || r_q_c[SQ_N-1].op == OP_MAG) begin
            d_src_c[0].sc = (root > 64'h7fffffff) ? W_MAX : root[31:0];
        end
        d_src_d[0] = (r_q_c[SQ_N-1].op == OP_NORM) ? root[31:0] : r_q_c[SQ_N-1].s_mag;
        for (int i = 0; i < 3; i++) begin
            d_src_rem[0][i] = '0;
            d_src_num[0][i] = r_q_num[SQ_N-1][i];
        end
        for (int k = 1; k < DV_N; k++) begin
            d_src_c[k] = r_d_c[k-1];
            d_src_d[k] = r_d_d[k-1];
            for (int i = 0; i < 3; i++) begin
                d_src_rem[k][i] = r_d_rem[k-1][i];
                d_src_num[k][i] = r_d_num[k-1][i];
            end
        end
        rem_sh = '0;
        for (int k = 0; k < DV_N; k++) begin
            for (int i = 0; i < 3; i++) begin
                rem_sh = {d_src_rem[k][i], d_src_num[k][i][NW-1]};
                if (rem_sh >= {1'b0, d_src_d[k]}) begin
                    n_d_rem[k][i] = 32'(rem_sh - {1'b0, d_src_d[k]});
                    n_d_num[k][i] = {d_src_num[k][i][NW-2:0], 1'b1};
                end else begin
                    n_d_rem[k][i] = rem_sh[31:0];
                    n_d_num[k][i] = {d_src_num[k][i][NW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= '0;
        end else if (en) begin
            r_d_vld <= {r_d_vld[DV_N-2:0], r_q_vld[SQ_N-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_c   <= d_src_c;
            r_d_d   <= d_src_d;
            r_d_rem <= n_d_rem;
            r_d_num <= n_d_num;
        end
    end

    // output stage
    logic              r_o_vld;
    logic [2:0][31:0]  r_o_v;
    logic [31:0]       r_o_sc;
    logic              r_o_eq;
    logic              r_o_err;

    t_carry           o_c;
    logic [2:0][31:0] n_o_v;
    logic [NW-1:0]    quo;

    localparam logic [NW-1:0] Q_POS_MAX = {{(NW-32){1'b0}}, 32'h7fffffff};
    localparam logic [NW-1:0] Q_NEG_MAX = {{(NW-32){1'b0}}, 32'h80000000};

    always_comb begin
        o_c   = r_d_c[DV_N-1];
        n_o_v = o_c.v;
        quo   = '0;
        if ((o_c.op == OP_DIV || o_c.op == OP_NORM) && !o_c.err) begin
            for (int i = 0; i < 3; i++) begin
                quo = r_d_num[DV_N-1][i];
                if (o_c.q_neg[i]) begin
                    n_o_v[i] = (quo > Q_NEG_MAX) ? W_MIN : 32'd0 - quo[31:0];
                end else begin
                    n_o_v[i] = (quo > Q_POS_MAX) ? W_MAX : quo[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_d_vld[DV_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_v   <= n_o_v;
            r_o_sc  <= o_c.sc;
            r_o_eq  <= o_c.eq;
            r_o_err <= o_c.err;
        end
    end

    assign o_empty      = !r_o_vld;
    assign o_out_x      = $signed(r_o_v[0]);
    assign o_out_y      = $signed(r_o_v[1]);
    assign o_out_z      = $signed(r_o_v[2]);
    assign o_out_scalar = $signed(r_o_sc);
    assign o_is_equal   = r_o_eq;
    assign o_error      = r_o_err;

endmodule

@@ hw/rtl/vector3_math_unit.sv @@
// Path from an accepted request to its result on the ports: queue, multiply, combine,
// 32 square-root stages, 32 + FRAC_BITS divider stages and the output register.
// Throughput: one request per cycle while the output is empty or popped; the square root
// and the divider are fully pipelined, and an unpopped result stalls the whole pipeline.
// Reset: synchronous, active low; empties the queue and clears all pipeline valids.
module vector3_math_unit #(
    parameter int FRAC_BITS   = vmu_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = vmu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic signed [31:0] i_scalar,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_scalar,
    output logic               o_is_equal,
    output logic               o_error
);
    import vmu_pkg::*;

    logic q_full;
    logic q_wr;
    t_req q_in;
    logic q_vld;
    t_req q_out;
    logic q_rd;

    vmu_front u_front (
        .i_push     (push),
        .i_func     (i_func),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_first_z  (i_first_z),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .i_scalar   (i_scalar),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_wr       (q_wr),
        .o_req      (q_in)
    );

    vmu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_vld   (q_vld),
        .o_data  (q_out)
    );

    vmu_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_vld    (q_vld),
        .i_req        (q_out),
        .o_req_rdy    (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_out_scalar (o_out_scalar),
        .o_is_equal   (o_is_equal),
        .o_error      (o_error)
    );

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    a_eq_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_equal) |-> !o_error)
        else $error("equal flag with error");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_out_x == 32'sd0 && o_out_y == 32'sd0
                                 && o_out_z == 32'sd0 && o_out_scalar == 32'sd0))
        else $error("nonzero result on error");
`endif

endmodule

@@ dv/vmu_checker.sv @@
module vmu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic signed [31:0] i_scalar,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] i_out_x,
    input  logic signed [31:0] i_out_y,
    input  logic signed [31:0] i_out_z,
    input  logic signed [31:0] i_out_scalar,
    input  logic               i_is_equal,
    input  logic               i_error,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import vmu_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] sc;
        logic               eq;
        logic               err;
    } t_vec_result;

    t_vec_result expected_results[$];

    function automatic logic signed [31:0] sat32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bpos;
        res  = 0;
        bpos = 64'd1 << 62;
        while (bpos > n) bpos = bpos >> 2;
        while (bpos != 0) begin
            if (n >= res + bpos) begin
                n   = n - (res + bpos);
                res = (res >> 1) + bpos;
            end else begin
                res = res >> 1;
            end
            bpos = bpos >> 2;
        end
        return res;
    endfunction

    function automatic t_vec_result predict_vector_op(
        logic [3:0] fn,
        logic signed [31:0] a0, logic signed [31:0] a1, logic signed [31:0] a2,
        logic signed [31:0] b0, logic signed [31:0] b1, logic signed [31:0] b2,
        logic signed [31:0] s32
    );
        t_vec_result r;
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] v[3];
        logic signed [127:0] s, sc, mw;
        logic [63:0] m;
        a[0] = a0; a[1] = a1; a[2] = a2;
        b[0] = b0; b[1] = b1; b[2] = b2;
        s  = s32;
        v[0] = 0; v[1] = 0; v[2] = 0;
        sc = 0;
        r.eq  = 1'b0;
        r.err = 1'b0;
        case (fn)
            FN_ADD:   for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
            FN_SUB:   for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
            FN_SCALE: for (int i = 0; i < 3; i++) v[i] = (a[i] * s) >>> FB;
            FN_DIV: begin
                if (s == 0) r.err = 1'b1;
                else for (int i = 0; i < 3; i++) v[i] = (a[i] <<< FB) / s;
            end
            FN_DOT:   sc = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB;
            FN_CROSS: begin
                v[0] = (a[1] * b[2] - a[2] * b[1]) >>> FB;
                v[1] = (a[2] * b[0] - a[0] * b[2]) >>> FB;
                v[2] = (a[0] * b[1] - a[1] * b[0]) >>> FB;
            end
            FN_MAG, FN_NORM: begin
                mw = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                m  = isqrt64(mw[63:0]);
                mw = $signed({64'd0, m});
                if (fn == FN_MAG) begin
                    sc = mw;
                end else if (m == 0) begin
                    r.err = 1'b1;
                end else begin
                    sc = mw;
                    for (int i = 0; i < 3; i++) v[i] = (a[i] <<< FB) / mw;
                end
            end
            FN_EQ:    r.eq = (a0 == b0) && (a1 == b1) && (a2 == b2);
            default:  r.err = 1'b1;
        endcase
        r.x  = sat32(v[0]);
        r.y  = sat32(v[1]);
        r.z  = sat32(v[2]);
        r.sc = sat32(sc);
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_vec_result e;
        if (i_rst_n && push && !full)
            expected_results.push_back(predict_vector_op(i_func, i_first_x, i_first_y,
                i_first_z, i_second_x, i_second_y, i_second_z, i_scalar));
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                o_fail_count <= o_fail_count + 1;
            end else begin
                e = expected_results.pop_front();
                o_checked <= o_checked + 1;
                if (i_out_x !== e.x || i_out_y !== e.y || i_out_z !== e.z ||
                    i_out_scalar !== e.sc || i_is_equal !== e.eq || i_error !== e.err)
                    o_fail_count <= o_fail_count + 1;
                if (i_out_x !== e.x)
                    $error("out_x expected %0d actual %0d", e.x, i_out_x);
                if (i_out_y !== e.y)
                    $error("out_y expected %0d actual %0d", e.y, i_out_y);
                if (i_out_z !== e.z)
                    $error("out_z expected %0d actual %0d", e.z, i_out_z);
                if (i_out_scalar !== e.sc)
                    $error("out_scalar expected %0d actual %0d", e.sc, i_out_scalar);
                if (i_is_equal !== e.eq)
                    $error("is_equal expected %0b actual %0b", e.eq, i_is_equal);
                if (i_error !== e.err)
                    $error("error expected %0b actual %0b", e.err, i_error);
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

@@ dv/tb_vector3_math_unit.sv @@
module tb_vector3_math_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import vmu_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [3:0]         i_func;
    logic signed [31:0] i_first_x, i_first_y, i_first_z;
    logic signed [31:0] i_second_x, i_second_y, i_second_z;
    logic signed [31:0] i_scalar;
    logic               empty;
    logic               pop;
    logic signed [31:0] o_out_x, o_out_y, o_out_z, o_out_scalar;
    logic               o_is_equal, o_error;
    int                 fail_count, pending, checked;
    int                 sent;

    localparam logic [31:0] MAXP = 32'h7fffffff;
    localparam logic [31:0] MAXN = 32'h80000000;
    localparam logic [31:0] ONE  = 32'h00010000;

    vector3_math_unit dut (.*);

    vmu_checker u_checker (
        .i_clk, .i_rst_n, .push, .full, .i_func,
        .i_first_x, .i_first_y, .i_first_z, .i_second_x, .i_second_y, .i_second_z,
        .i_scalar, .empty, .pop,
        .i_out_x(o_out_x), .i_out_y(o_out_y), .i_out_z(o_out_z),
        .i_out_scalar(o_out_scalar), .i_is_equal(o_is_equal), .i_error(o_error),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400us;
        $display("Some tests failed");
        $finish;
    end

    // receiver stall pattern: pop follows a randomly chosen mode that changes at random
    initial begin
        int mode;
        pop  = 1'b0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(63) == 0) mode = $urandom_range(3);
            case (mode)
                0:       pop = 1'b1;
                1:       pop = $urandom_range(1);
                2:       pop = ($urandom_range(3) == 0);
                default: pop = ($urandom_range(15) != 0);
            endcase
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097151)) - 1048576);
            2: case ($urandom_range(4))
                   0: return MAXP;
                   1: return MAXN;
                   2: return 32'd0;
                   3: return 32'd1;
                   default: return 32'hffffffff;
               endcase
            3: return 32'($signed($urandom_range(32'h3ffff)) - 32'sh20000);
            default: return 32'($signed($urandom_range(32'h3fffff)) - 32'sh200000);
        endcase
    endfunction

    task automatic send_req(input logic [3:0] fn, input logic [31:0] ax, input logic [31:0] ay,
                            input logic [31:0] az, input logic [31:0] bx,
                            input logic [31:0] by, input logic [31:0] bz,
                            input logic [31:0] s);
        i_func = fn;
        i_first_x = ax; i_first_y = ay; i_first_z = az;
        i_second_x = bx; i_second_y = by; i_second_z = bz;
        i_scalar = s;
        push = 1'b1;
        while (full) @(negedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic maybe_gap(input int burst_left);
        if (burst_left == 0) begin
            push = 1'b0;
            repeat ($urandom_range(8)) @(negedge i_clk);
        end
    endtask

    initial begin
        logic [3:0]  fn;
        logic [31:0] ax, ay, az, bx, by, bz, s;
        int burst;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_func = FN_ADD;
        i_first_x = 0; i_first_y = 0; i_first_z = 0;
        i_second_x = 0; i_second_y = 0; i_second_z = 0;
        i_scalar = 0;
        sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_req(FN_ADD, MAXP, MAXN, ONE, MAXP, MAXN, ONE, 0);
        send_req(FN_SUB, MAXP, MAXN, 0, MAXN, MAXP, ONE, 0);
        send_req(FN_SCALE, MAXP, MAXN, ONE, 0, 0, 0, MAXP);
        send_req(FN_SCALE, MAXN, 32'hffffffff, 3, 0, 0, 0, MAXN);
        send_req(FN_DIV, MAXP, MAXN, ONE, 0, 0, 0, 1);
        send_req(FN_DIV, MAXP, 7, 32'hfffffff9, 0, 0, 0, 32'hfffe0000);
        send_req(FN_DIV, ONE, ONE, ONE, 0, 0, 0, 0);
        send_req(FN_DOT, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, 0);
        send_req(FN_DOT, MAXP, MAXN, ONE, MAXN, MAXP, ONE, 0);
        send_req(FN_CROSS, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, 0);
        send_req(FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
        send_req(FN_MAG, MAXN, MAXN, MAXN, 0, 0, 0, 0);
        send_req(FN_MAG, 0, 0, 0, 0, 0, 0, 0);
        send_req(FN_NORM, MAXN, MAXN, MAXN, 0, 0, 0, 0);
        send_req(FN_NORM, 0, 0, 1, 0, 0, 0, 0);
        send_req(FN_NORM, 0, 0, 0, 0, 0, 0, 0);
        send_req(FN_EQ, MAXP, MAXN, 1, MAXP, MAXN, 1, 0);
        send_req(FN_EQ, MAXP, MAXN, 1, MAXP, MAXN, 0, 0);
        send_req(4'd9, 1, 2, 3, 4, 5, 6, 7);
        send_req(4'd15, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP);
        push = 1'b0;

        burst = 0;
        repeat (1250) begin
            if (burst == 0) burst = $urandom_range(1, 40);
            fn = ($urandom_range(15) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(FN_EQ));
            ax = rand_comp(); ay = rand_comp(); az = rand_comp();
            bx = rand_comp(); by = rand_comp(); bz = rand_comp();
            s  = rand_comp();
            case ($urandom_range(9))
                0: s = 0;
                1: begin ax = 0; ay = 0; az = 0; end
                2: begin bx = ax; by = ay; bz = az; end
                default: ;
            endcase
            send_req(fn, ax, ay, az, bx, by, bz, s);
            burst--;
            maybe_gap(burst);
        end
        push = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Sent %0d requests across all operations, unknown codes and edge values;",
                 sent);
        $display("checked %0d results under random sender gaps and receiver stalls.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
